>>> hw/rtl/pcpg_pkg.sv
package pcpg_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int TRIG_ITERATIONS_DEF = 16;

  localparam int SCREEN_ORIGIN_X = 600;
  localparam int SCREEN_ORIGIN_Y = 350;

  // Trig values are Q30; the shared arithmetic unit works on OP_W-bit operands.
  localparam int Q_FRAC  = 30;
  localparam int OP_W    = Q_FRAC + 1;
  localparam int SUM_W   = OP_W + 1;
  localparam int PIX_W   = 13;
  localparam int CTR_W   = 11;
  localparam int RAD_W   = 10;
  localparam int DIV_D_W = 12;
  localparam int K_ARG_W = 5;
  localparam int RPD_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam longint unsigned RAD_PER_DEG_L = ((64'd314 << Q_FRAC) + 64'd9000) / 64'd18000;
  localparam logic [RPD_W-1:0] RAD_PER_DEG = RPD_W'(RAD_PER_DEG_L);
  localparam logic [OP_W-1:0]  Q_ONE       = OP_W'(1) << Q_FRAC;
  localparam logic [OP_W-1:0]  Q_HALF      = OP_W'(1) << (Q_FRAC - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic mul_start;
    logic div_start;
  } arith_ctrl_t;

  // Divisor of the k-th sine term: (2k)(2k+1).
  function automatic logic [DIV_D_W-1:0] div_sin(input logic [K_ARG_W-1:0] k);
    logic [DIV_D_W-1:0] e;
    e = DIV_D_W'({k, 1'b0});
    return e * (e + DIV_D_W'(1));
  endfunction

  // Divisor of the k-th cosine term: (2k-1)(2k).
  function automatic logic [DIV_D_W-1:0] div_cos(input logic [K_ARG_W-1:0] k);
    logic [DIV_D_W-1:0] e;
    e = DIV_D_W'({k, 1'b0});
    return e * (e - DIV_D_W'(1));
  endfunction

endpackage

>>> hw/rtl/pcpg_arith.sv
module pcpg_arith (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcpg_pkg::arith_ctrl_t           ctrl_i,
  input  logic [pcpg_pkg::OP_W-1:0]       mul_a_i,
  input  logic [pcpg_pkg::OP_W-1:0]       mul_b_i,
  input  logic [pcpg_pkg::OP_W-1:0]       div_n_i,
  input  logic [pcpg_pkg::DIV_D_W-1:0]    div_d_i,
  output logic [2*pcpg_pkg::OP_W-1:0]     prod_o,
  output logic [pcpg_pkg::OP_W-1:0]       quo_o,
  output logic                            done_o
);
  import pcpg_pkg::*;

  localparam int CNT_W = $clog2(OP_W + 1);

  logic [2*OP_W-1:0]  prod_q, prod_d;
  logic [OP_W-1:0]    mcand_q, mcand_d;
  logic [OP_W-1:0]    quo_q, quo_d;
  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_D_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               is_div_q, is_div_d;
  logic               done_q, done_d;

  logic [OP_W:0]      acc;
  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W+1:0] diff;

  // Multiplication retires one multiplier bit per cycle, division one quotient bit.
  always_comb begin
    acc     = {1'b0, prod_q[2*OP_W-1:OP_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    shifted = {rem_q, quo_q[OP_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};

    prod_d   = prod_q;
    mcand_d  = mcand_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    is_div_d = is_div_q;
    done_d   = 1'b0;

    if (ctrl_i.mul_start || ctrl_i.div_start) begin
      busy_d   = 1'b1;
      is_div_d = ctrl_i.div_start;
      cnt_d    = CNT_W'(OP_W);
      prod_d   = {{OP_W{1'b0}}, mul_b_i};
      mcand_d  = mul_a_i;
      quo_d    = div_n_i;
      rem_d    = '0;
      dvs_d    = div_d_i;
    end else if (busy_q) begin
      if (is_div_q) begin
        if (!diff[DIV_D_W+1]) begin
          rem_d = diff[DIV_D_W-1:0];
          quo_d = {quo_q[OP_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[DIV_D_W-1:0];
          quo_d = {quo_q[OP_W-2:0], 1'b0};
        end
      end else begin
        prod_d = {acc, prod_q[OP_W-1:1]};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      busy_q   <= busy_d;
      is_div_q <= is_div_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

  assign prod_o = prod_q;
  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/parametric_circle_point_generator_unit.sv
// Channel   Dir  Handshake         Content
// s_axis    in   tvalid / tready   tdata: start_req
// m_axis    out  tvalid / tready   tdata: pixel_x, pixel_y; tlast: last; tuser: done_res
// cfg       in   we                idx selects center_x, center_y or radius
//
// A start beat runs the step division, then gives four axis beats.
// An angle tick runs the Taylor terms until both series reach zero, at most
// TRIG_ITERATIONS - 1 of them, before its eight beats; every multiply and divide
// runs in the one shared bit-serial unit.
// A tick at the end angle gives one done beat.
// Reset leaves center 0, radius 1 and no sweep; no clearing pass is needed.
// Beats hold while m_axis_tready_i is low, and no input is taken until a run is out.
module parametric_circle_point_generator_unit #(
  parameter int ANGLE_FRAC_BITS = pcpg_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = pcpg_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,   // [0] start_req
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o,   // [12:0] pixel_x, [25:13] pixel_y
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tuser_o,   // [0] done_res
  input  logic                              cfg_we_i,
  input  logic [pcpg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcpg_pkg::CTR_W-1:0]        cfg_wdata_i
);
  import pcpg_pkg::*;

  localparam int ANG_W  = ANGLE_FRAC_BITS + 6;
  localparam int STEP_W = ANGLE_FRAC_BITS + 1;
  localparam int K_W    = $clog2(TRIG_ITERATIONS + 1);
  localparam int V_W    = Q_FRAC + PIX_W - 2;

  localparam logic [ANG_W-1:0] ANG_ONE   = ANG_W'(1) << ANGLE_FRAC_BITS;
  localparam logic [ANG_W-1:0] ANG_END   = ANG_W'(45) << ANGLE_FRAC_BITS;
  localparam logic [ANG_W-1:0] ANG_LIMIT = ANG_W'(46) << ANGLE_FRAC_BITS;
  localparam logic [OP_W-1:0]  STEP_ONE  = OP_W'(1) << ANGLE_FRAC_BITS;
  localparam logic [K_W-1:0]   K_END     = K_W'(TRIG_ITERATIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_RAD, S_X2, S_TERM, S_TS_MUL, S_TS_DIV, S_TC_MUL, S_TC_DIV,
    S_VC, S_VS, S_AXIS, S_ARC, S_DONE
  } state_e;

  state_e                    state_q;
  logic [2:0]                idx_q;
  logic [STEP_W-1:0]         step_q;
  logic [ANG_W-1:0]          angle_q;
  logic                      active_q;
  logic [K_W-1:0]            k_q;
  logic [OP_W-1:0]           x2_q, ts_q, tc_q;
  logic signed [SUM_W-1:0]   ss_q, cc_q;
  logic [PIX_W-1:0]          xp_q, xm_q, yp_q, ym_q;
  arith_ctrl_t               ctrl_q;
  logic [OP_W-1:0]           mul_a_q, mul_b_q, div_n_q;
  logic [DIV_D_W-1:0]        div_d_q;

  logic signed [CTR_W-1:0]   center_x_q, center_y_q;
  logic [RAD_W-1:0]          radius_q;

  logic [2*OP_W-1:0]         prod;
  logic [OP_W-1:0]           quo;
  logic                      ar_done;

  logic [OP_W:0]             rad_sum;
  logic [OP_W-1:0]           rad;
  logic [OP_W-1:0]           q_prod;
  logic [V_W:0]              v_plus;
  logic [V_W+1:0]            v_minus;
  logic [PIX_W-1:0]          off_p, off_m;
  logic [PIX_W-1:0]          xc, yc, rr, off_x, off_y;
  logic [PIX_W-1:0]          pix_x, pix_y;
  logic                      last;

  function automatic logic [OP_W-1:0] clamp_q(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] one_s;
    one_s = $signed({1'b0, Q_ONE});
    if (v < 0) return '0;
    if (v > one_s) return Q_ONE;
    return v[OP_W-1:0];
  endfunction

  pcpg_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_q),
    .mul_a_i(mul_a_q),
    .mul_b_i(mul_b_q),
    .div_n_i(div_n_q),
    .div_d_i(div_d_q),
    .prod_o (prod),
    .quo_o  (quo),
    .done_o (ar_done)
  );

  always_comb begin
    rad_sum = prod[ANGLE_FRAC_BITS+OP_W-1:ANGLE_FRAC_BITS-1] + (OP_W+1)'(1);
    rad     = rad_sum[OP_W:1];
    q_prod  = prod[Q_FRAC+OP_W-1:Q_FRAC];
    v_plus  = {1'b0, prod[V_W-1:0]} + (V_W+1)'(Q_HALF);
    v_minus = (V_W+2)'(Q_HALF) - {2'b00, prod[V_W-1:0]};
    off_p   = {1'b0, v_plus[V_W:Q_FRAC]};
    off_m   = v_minus[V_W+1:Q_FRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= RAD_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: center_x_q <= cfg_wdata_i;
        CFG_CENTER_Y: center_y_q <= cfg_wdata_i;
        CFG_RADIUS:   radius_q   <= cfg_wdata_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      step_q   <= '0;
      angle_q  <= ANG_ONE;
      active_q <= 1'b0;
      k_q      <= '0;
      x2_q     <= '0;
      ts_q     <= '0;
      tc_q     <= '0;
      ss_q     <= '0;
      cc_q     <= '0;
      xp_q     <= '0;
      xm_q     <= '0;
      yp_q     <= '0;
      ym_q     <= '0;
      ctrl_q   <= '0;
      mul_a_q  <= '0;
      mul_b_q  <= '0;
      div_n_q  <= '0;
      div_d_q  <= '0;
    end else begin
      ctrl_q <= '0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            if (s_axis_tdata_i[0]) begin
              div_n_q          <= STEP_ONE + OP_W'(radius_q[RAD_W-1:1]);
              div_d_q          <= (radius_q == '0) ? DIV_D_W'(1) : DIV_D_W'(radius_q);
              ctrl_q.div_start <= 1'b1;
              state_q          <= S_STEP;
            end else if (active_q) begin
              if (angle_q >= ANG_END) begin
                active_q <= 1'b0;
                state_q  <= S_DONE;
              end else begin
                mul_a_q          <= OP_W'(angle_q);
                mul_b_q          <= OP_W'(RAD_PER_DEG);
                ctrl_q.mul_start <= 1'b1;
                state_q          <= S_RAD;
              end
            end
          end
        end
        S_STEP: begin
          if (ar_done) begin
            step_q   <= (quo[STEP_W-1:0] == '0) ? STEP_W'(1) : quo[STEP_W-1:0];
            angle_q  <= ANG_ONE;
            active_q <= 1'b1;
            idx_q    <= '0;
            state_q  <= S_AXIS;
          end
        end
        S_RAD: begin
          if (ar_done) begin
            ts_q             <= rad;
            ss_q             <= $signed({1'b0, rad});
            tc_q             <= Q_ONE;
            cc_q             <= $signed({1'b0, Q_ONE});
            mul_a_q          <= rad;
            mul_b_q          <= rad;
            ctrl_q.mul_start <= 1'b1;
            state_q          <= S_X2;
          end
        end
        S_X2: begin
          if (ar_done) begin
            x2_q    <= q_prod;
            k_q     <= K_W'(1);
            state_q <= S_TERM;
          end
        end
        S_TERM: begin
          // Once both terms are zero every later term is zero as well.
          if (k_q == K_END || (ts_q == '0 && tc_q == '0)) begin
            mul_a_q <= clamp_q(cc_q);
            mul_b_q <= OP_W'(radius_q);
            state_q <= S_VC;
          end else begin
            mul_a_q <= ts_q;
            mul_b_q <= x2_q;
            state_q <= S_TS_MUL;
          end
          ctrl_q.mul_start <= 1'b1;
        end
        S_TS_MUL: begin
          if (ar_done) begin
            div_n_q          <= q_prod;
            div_d_q          <= div_sin(K_ARG_W'(k_q));
            ctrl_q.div_start <= 1'b1;
            state_q          <= S_TS_DIV;
          end
        end
        S_TS_DIV: begin
          if (ar_done) begin
            ts_q             <= quo;
            mul_a_q          <= tc_q;
            mul_b_q          <= x2_q;
            ctrl_q.mul_start <= 1'b1;
            state_q          <= S_TC_MUL;
          end
        end
        S_TC_MUL: begin
          if (ar_done) begin
            div_n_q          <= q_prod;
            div_d_q          <= div_cos(K_ARG_W'(k_q));
            ctrl_q.div_start <= 1'b1;
            state_q          <= S_TC_DIV;
          end
        end
        S_TC_DIV: begin
          if (ar_done) begin
            tc_q <= quo;
            if (k_q[0]) begin
              ss_q <= ss_q - $signed({1'b0, ts_q});
              cc_q <= cc_q - $signed({1'b0, quo});
            end else begin
              ss_q <= ss_q + $signed({1'b0, ts_q});
              cc_q <= cc_q + $signed({1'b0, quo});
            end
            k_q     <= k_q + K_W'(1);
            state_q <= S_TERM;
          end
        end
        S_VC: begin
          if (ar_done) begin
            xp_q             <= off_p;
            xm_q             <= off_m;
            mul_a_q          <= clamp_q(ss_q);
            mul_b_q          <= OP_W'(radius_q);
            ctrl_q.mul_start <= 1'b1;
            state_q          <= S_VS;
          end
        end
        S_VS: begin
          if (ar_done) begin
            yp_q    <= off_p;
            ym_q    <= off_m;
            angle_q <= angle_q + ANG_W'(step_q);
            idx_q   <= '0;
            state_q <= S_ARC;
          end
        end
        S_AXIS: begin
          if (m_axis_tready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd3) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_ARC: begin
          if (m_axis_tready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    xc    = PIX_W'(SCREEN_ORIGIN_X) + {{(PIX_W-CTR_W){center_x_q[CTR_W-1]}}, center_x_q};
    yc    = PIX_W'(SCREEN_ORIGIN_Y) - {{(PIX_W-CTR_W){center_y_q[CTR_W-1]}}, center_y_q};
    rr    = PIX_W'(radius_q);
    off_x = '0;
    off_y = '0;
    last  = 1'b0;
    if (state_q == S_AXIS) begin
      case (idx_q[1:0])
        2'd0: off_y = rr;
        2'd1: off_y = -rr;
        2'd2: off_x = rr;
        default: begin
          off_x = -rr;
          last  = 1'b1;
        end
      endcase
    end else begin
      case (idx_q)
        3'd0: begin off_x = xp_q; off_y = yp_q; end
        3'd1: begin off_x = xp_q; off_y = ym_q; end
        3'd2: begin off_x = xm_q; off_y = yp_q; end
        3'd3: begin off_x = xm_q; off_y = ym_q; end
        3'd4: begin off_x = yp_q; off_y = xp_q; end
        3'd5: begin off_x = yp_q; off_y = xm_q; end
        3'd6: begin off_x = ym_q; off_y = xp_q; end
        default: begin
          off_x = ym_q;
          off_y = xm_q;
          last  = 1'b1;
        end
      endcase
    end
    if (state_q == S_DONE) begin
      pix_x = '0;
      pix_y = '0;
    end else begin
      pix_x = xc + off_x;
      pix_y = yc + off_y;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_AXIS) || (state_q == S_ARC) || (state_q == S_DONE);
  assign m_axis_tdata_o  = {{(32-2*PIX_W){1'b0}}, pix_y, pix_x};
  assign m_axis_tlast_o  = (state_q == S_DONE) || last;
  assign m_axis_tuser_o  = (state_q == S_DONE);

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while a result beat is pending");

  a_done_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("done beat without tlast or with pixel data");

  a_step_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_q != '0))
    else $error("sweep running with a zero angle step");

  a_angle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q < ANG_LIMIT)
    else $error("sweep angle ran past its end");

endmodule

>>> tb/pcpg_point_checker.sv
`timescale 1ns / 100ps
module pcpg_point_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [7:0]                     s_axis_tdata_i,   // [0] start_req
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [31:0]                    m_axis_tdata_i,   // [12:0] pixel_x, [25:13] pixel_y
  input  logic                           m_axis_tlast_i,
  input  logic                           m_axis_tuser_i,   // [0] done_res
  input  logic                           cfg_we_i,
  input  logic [pcpg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcpg_pkg::CTR_W-1:0]     cfg_wdata_i,
  output int                             pending_o,
  output int                             errors_o
);
  import pcpg_pkg::*;

  localparam int FRAC = ANGLE_FRAC_BITS_DEF;
  localparam int TERMS = TRIG_ITERATIONS_DEF;
  localparam longint Q1 = longint'(1) << 30;
  localparam longint RAD_STEP = ((longint'(314) << 30) + longint'(9000)) / longint'(18000);
  localparam logic [23:0] ANGLE_ONE = 24'(1) << FRAC;
  localparam logic [23:0] ANGLE_END = 24'(45) << FRAC;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             done;
  } point_t;

  logic signed [CTR_W-1:0] cx_q;
  logic signed [CTR_W-1:0] cy_q;
  logic [RAD_W-1:0]        rad_q;
  logic [23:0]             angle_q;
  logic [23:0]             step_q;
  logic                    active_q;
  point_t                  points_due[$];
  int                      errors = 0;

  function automatic void flag(string field, longint want, longint got);
    errors++;
    if (errors <= 200) begin
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  function automatic void due_point(longint x, longint y, logic last, logic done);
    point_t p;
    p.px = PIX_W'(x);
    p.py = PIX_W'(y);
    p.last = last;
    p.done = done;
    points_due.push_back(p);
  endfunction

  function automatic void trig_q30(input longint x, output longint s, output longint c);
    longint x2, ts, tc, ss, cc;
    int k;
    x2 = (x * x) >>> 30;
    ts = x;
    tc = Q1;
    ss = x;
    cc = Q1;
    for (k = 1; k < TERMS; k++) begin
      ts = ((ts * x2) >>> 30) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >>> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= ts;
        cc -= tc;
      end else begin
        ss += ts;
        cc += tc;
      end
    end
    s = (ss < 0) ? 0 : (ss > Q1) ? Q1 : ss;
    c = (cc < 0) ? 0 : (cc > Q1) ? Q1 : cc;
  endfunction

  function automatic void predict_points(input logic start);
    longint xc, yc, r, d, rad, s, c, xp, xm, yp, ym;
    xc = SCREEN_ORIGIN_X + longint'(cx_q);
    yc = SCREEN_ORIGIN_Y - longint'(cy_q);
    r = longint'(rad_q);
    if (start) begin
      d = (rad_q == '0) ? 1 : r;
      step_q = 24'(((longint'(1) << FRAC) + d / 2) / d);
      if (step_q == '0) begin
        step_q = 24'd1;
      end
      angle_q = ANGLE_ONE;
      active_q = 1'b1;
      due_point(xc, yc + r, 1'b0, 1'b0);
      due_point(xc, yc - r, 1'b0, 1'b0);
      due_point(xc + r, yc, 1'b0, 1'b0);
      due_point(xc - r, yc, 1'b1, 1'b0);
    end else if (active_q && angle_q >= ANGLE_END) begin
      active_q = 1'b0;
      due_point(0, 0, 1'b1, 1'b1);
    end else if (active_q) begin
      rad = (longint'(angle_q) * RAD_STEP + (longint'(1) << (FRAC - 1))) >>> FRAC;
      trig_q30(rad, s, c);
      xp = (Q1 / 2 + r * c) >>> 30;
      xm = (Q1 / 2 - r * c) >>> 30;
      yp = (Q1 / 2 + r * s) >>> 30;
      ym = (Q1 / 2 - r * s) >>> 30;
      due_point(xc + xp, yc + yp, 1'b0, 1'b0);
      due_point(xc + xp, yc + ym, 1'b0, 1'b0);
      due_point(xc + xm, yc + yp, 1'b0, 1'b0);
      due_point(xc + xm, yc + ym, 1'b0, 1'b0);
      due_point(xc + yp, yc + xp, 1'b0, 1'b0);
      due_point(xc + yp, yc + xm, 1'b0, 1'b0);
      due_point(xc + ym, yc + xp, 1'b0, 1'b0);
      due_point(xc + ym, yc + xm, 1'b1, 1'b0);
      angle_q = angle_q + step_q;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t got, want;
    if (!rst_ni) begin
      cx_q = '0;
      cy_q = '0;
      rad_q = RAD_W'(1);
      angle_q = ANGLE_ONE;
      step_q = '0;
      active_q = 1'b0;
      points_due.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.px = m_axis_tdata_i[PIX_W-1:0];
        got.py = m_axis_tdata_i[2*PIX_W-1:PIX_W];
        got.last = m_axis_tlast_i;
        got.done = m_axis_tuser_i;
        if (points_due.size() == 0) begin
          errors++;
          $error("beat with no point due: pixel_x %0d, pixel_y %0d",
                 $signed(got.px), $signed(got.py));
        end else begin
          want = points_due.pop_front();
          if (got.px !== want.px) flag("pixel_x", $signed(want.px), $signed(got.px));
          if (got.py !== want.py) flag("pixel_y", $signed(want.py), $signed(got.py));
          if (got.last !== want.last) flag("last", want.last, got.last);
          if (got.done !== want.done) flag("done_res", want.done, got.done);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_points(s_axis_tdata_i[0]);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X: cx_q = cfg_wdata_i;
          CFG_CENTER_Y: cy_q = cfg_wdata_i;
          CFG_RADIUS:   rad_q = cfg_wdata_i[RAD_W-1:0];
          default: ;
        endcase
      end
      pending_o <= points_due.size();
      errors_o <= errors;
    end
  end

endmodule

>>> tb/tb_parametric_circle_point_generator_unit.sv
`timescale 1ns / 100ps
module tb_parametric_circle_point_generator_unit;
  import pcpg_pkg::*;

  localparam int RANDOM_ITEMS = 220;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i = '0;   // [0] start_req
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [31:0]          m_axis_tdata_o;        // [12:0] pixel_x, [25:13] pixel_y
  logic                 m_axis_tlast_o;
  logic                 m_axis_tuser_o;        // [0] done_res
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_CENTER_X;
  logic [CTR_W-1:0]     cfg_wdata_i = '0;

  int pending;
  int errors;
  int cycles = 0;
  int send_gap_pct = 16;
  int take_gap_pct = 62;

  parametric_circle_point_generator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  pcpg_point_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    m_axis_tready_i <= ($urandom_range(99) >= take_gap_pct);
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("parametric_circle_point_generator_unit: mismatch");
    $finish;
  end

  task automatic send_item(input logic start);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, start};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CTR_W-1:0] cx, input logic [CTR_W-1:0] cy,
                          input logic [CTR_W-1:0] r);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CENTER_X;
    cfg_wdata_i <= cx;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CENTER_Y;
    cfg_wdata_i <= cy;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RADIUS;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int counted;
    int cut;
    int k;
    logic live;
    logic start_bit;
    logic [RAD_W-1:0] r;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A tick with no sweep running gives no beat.
    send_item(1'b0);
    set_regs(11'd1023, 11'h400, 11'd1023);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    set_regs(11'h400, 11'd1023, 11'd0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    // New center and radius while the sweep is still running; bit 10 of the radius is junk.
    set_regs(11'h7FF, 11'd1, 11'h405);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);

    counted = 0;
    live = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end else if (counted >= RANDOM_ITEMS / 3) begin
        send_gap_pct = 62;
        take_gap_pct = 16;
      end
      if ($urandom_range(9) < 7) begin
        set_regs(11'($urandom), 11'($urandom), {1'($urandom), 9'd0, 1'($urandom)});
        send_item(1'b1);
        counted++;
        cut = ($urandom_range(5) == 0) ? $urandom_range(1, 40) : 45;
        for (k = 0; k < cut; k++) begin
          if ($urandom_range(11) == 0) begin
            r = ($urandom_range(3) == 0) ? RAD_W'(1023 * $urandom_range(1)) : RAD_W'($urandom);
            set_regs(11'($urandom), 11'($urandom), {1'($urandom), r});
          end
          send_item(1'b0);
          counted++;
        end
        live = (cut < 45);
        if (!live) begin
          repeat ($urandom_range(2)) send_item(1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          start_bit = 1'($urandom);
          send_item(start_bit);
          if (start_bit || live) counted++;
          live = live || start_bit;
        end
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("parametric_circle_point_generator_unit: match");
    end else begin
      $display("parametric_circle_point_generator_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> parametric_circle_point_generator_unit.f
hw/rtl/pcpg_pkg.sv
hw/rtl/pcpg_arith.sv
hw/rtl/parametric_circle_point_generator_unit.sv
tb/pcpg_point_checker.sv
tb/tb_parametric_circle_point_generator_unit.sv
